[rtl/wpf_pkg.sv]
// Package for the wildcard path filter match unit.
// Holds character codes, item kinds, controller states, command and status types.
// No dependencies.
package wpf_pkg;

    localparam int MAX_CHARS_DEF = 64;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    typedef enum logic [1:0] {
        KIND_PAT  = 2'd0,
        KIND_NAME = 2'd1,
        KIND_EVAL = 2'd2,
        KIND_CLR  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DISPATCH,
        ST_RUN_LOAD,
        ST_RUN_STEP,
        ST_CMP_ISSUE,
        ST_CMP_TEST,
        ST_CLS_LOAD,
        ST_CLS_STEP,
        ST_SKIP_LOAD,
        ST_SKIP_STEP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_WIN,
        OP_ADV,
        OP_F1,
        OP_STAR,
        OP_RUN,
        OP_CLS_OPEN,
        OP_CLS_STEP,
        OP_CMP_INIT,
        OP_CMP_ISSUE,
        OP_CMP_TEST,
        OP_FIN_T,
        OP_FIN_F
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic win_done;
        logic p0_zero;
        logic p0_star;
        logic p0_quest;
        logic p0_lbr;
        logic p1_rbr;
        logic lit_eq;
        logic cls_break;
        logic found;
        logic run_term;
        logic run_zero;
        logic run_gt_rem;
        logic cmp_eq;
        logic cmp_last_j;
        logic cmp_last_i;
    } status_t;

    function automatic logic [7:0] map_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_BSLASH || c == CH_COLON)
        begin
            r = CH_SLASH;
        end
        return r;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

[rtl/wpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/wpf_ctrl.sv]
// Controller state machine of the wildcard path filter match unit.
// Depends on wpf_pkg; drives commands to wpf_dp and reads its status.
module wpf_ctrl
    import wpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic [1:0] kind,
    input  status_t st,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_ACCEPT;
                    if (kind == KIND_EVAL)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.op = OP_WIN;
                if (st.win_done)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (st.p0_zero)
                begin
                    cmd.op     = OP_FIN_T;
                    state_next = ST_IDLE;
                end
                else if (st.p0_star)
                begin
                    cmd.op     = OP_STAR;
                    state_next = ST_RUN_LOAD;
                end
                else if (st.p0_quest)
                begin
                    cmd.op     = OP_ADV;
                    state_next = ST_LOAD;
                end
                else if (st.p0_lbr && st.p1_rbr)
                begin
                    cmd.op     = OP_F1;
                    state_next = ST_LOAD;
                end
                else if (st.p0_lbr)
                begin
                    cmd.op     = OP_CLS_OPEN;
                    state_next = ST_CLS_LOAD;
                end
                else if (st.lit_eq)
                begin
                    cmd.op     = OP_ADV;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.op     = OP_FIN_F;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN_LOAD:
            begin
                cmd.op = OP_WIN;
                if (st.win_done)
                begin
                    state_next = ST_RUN_STEP;
                end
            end
            ST_RUN_STEP:
            begin
                priority if (!st.run_term)
                begin
                    cmd.op     = OP_RUN;
                    state_next = ST_RUN_LOAD;
                end
                else if (st.run_zero)
                begin
                    state_next = ST_LOAD;
                end
                else if (st.run_gt_rem)
                begin
                    cmd.op     = OP_FIN_F;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_CMP_INIT;
                    state_next = ST_CMP_ISSUE;
                end
            end
            ST_CMP_ISSUE:
            begin
                cmd.op     = OP_CMP_ISSUE;
                state_next = ST_CMP_TEST;
            end
            ST_CMP_TEST:
            begin
                priority if (st.cmp_eq && st.cmp_last_j)
                begin
                    cmd.op     = OP_CMP_TEST;
                    state_next = ST_LOAD;
                end
                else if (!st.cmp_eq && st.cmp_last_i)
                begin
                    cmd.op     = OP_FIN_F;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_CMP_TEST;
                    state_next = ST_CMP_ISSUE;
                end
            end
            ST_CLS_LOAD:
            begin
                cmd.op = OP_WIN;
                if (st.win_done)
                begin
                    state_next = ST_CLS_STEP;
                end
            end
            ST_CLS_STEP:
            begin
                priority if (st.p0_zero || st.found || st.cls_break)
                begin
                    if (st.found)
                    begin
                        state_next = ST_SKIP_LOAD;
                    end
                    else
                    begin
                        cmd.op     = OP_FIN_F;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = OP_CLS_STEP;
                    state_next = ST_CLS_LOAD;
                end
            end
            ST_SKIP_LOAD:
            begin
                cmd.op = OP_WIN;
                if (st.win_done)
                begin
                    state_next = ST_SKIP_STEP;
                end
            end
            ST_SKIP_STEP:
            begin
                if (st.p0_zero || st.cls_break)
                begin
                    cmd.op     = OP_ADV;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.op     = OP_F1;
                    state_next = ST_SKIP_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/wpf_dp.sv]
// Datapath of the wildcard path filter match unit: stores, cursors and compares.
// Depends on wpf_pkg and wpf_ram; driven by commands from wpf_ctrl.
module wpf_dp
    import wpf_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] kind,
    input  logic [7:0] char_value,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  cmd_t       cmd,
    output status_t    st,
    output logic       done,
    output logic       matched
);

    localparam int AW = $clog2(MAX_CHARS);
    localparam int PW = AW + 2;

    logic [AW-1:0] pl_reg, pl_next, nl_reg, nl_next;
    logic [PW-1:0] f_reg, f_next, n_reg, n_next, s_reg, s_next;
    logic [PW-1:0] run_reg, run_next, i_reg, i_next, j_reg, j_next, lim_reg, lim_next;
    logic [2:0]    k_reg, k_next;
    logic [7:0]    p_reg [4];
    logic [7:0]    p_next [4];
    logic [7:0]    nb_reg, nb_next, nc_reg, nc_next;
    logic          found_reg, found_next, cs_reg;
    logic          matched_reg, matched_next, done_reg, done_next;
    logic          p_ok_reg, n_ok_reg;

    logic [PW-1:0] pa, na, rem;
    logic [7:0]    p_rdata, n_rdata, pb, nbyte, mapped, fp0, fp2;
    logic          p_we, n_we, is_range;

    assign mapped = map_byte(char_value);
    assign p_we = (cmd.op == OP_ACCEPT) && (kind == KIND_PAT) && (char_value != CH_NUL)
                  && (pl_reg != AW'(MAX_CHARS - 1));
    assign n_we = (cmd.op == OP_ACCEPT) && (kind == KIND_NAME) && (char_value != CH_NUL)
                  && (nl_reg != AW'(MAX_CHARS - 1));

    assign pa = (cmd.op == OP_CMP_ISSUE) ? s_reg + j_reg : f_reg + PW'(k_reg);
    assign na = (cmd.op == OP_CMP_ISSUE) ? n_reg + i_reg + j_reg : n_reg;

    wpf_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_pat_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (pl_reg),
        .wdata (mapped),
        .raddr (pa[AW-1:0]),
        .rdata (p_rdata)
    );

    wpf_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_name_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (nl_reg),
        .wdata (mapped),
        .raddr (na[AW-1:0]),
        .rdata (n_rdata)
    );

    assign pb    = p_ok_reg ? p_rdata : CH_NUL;
    assign nbyte = n_ok_reg ? n_rdata : CH_NUL;
    assign fp0   = fold(p_reg[0], cs_reg);
    assign fp2   = fold(p_reg[2], cs_reg);
    assign rem   = (PW'(nl_reg) > n_reg) ? PW'(nl_reg) - n_reg : '0;
    assign is_range = (p_reg[1] == CH_DASH) && (p_reg[2] != CH_NUL)
                      && ((p_reg[2] != CH_RBR) || (p_reg[3] == CH_RBR));

    always_comb
    begin
        st.win_done   = (k_reg == 3'd4);
        st.p0_zero    = (p_reg[0] == CH_NUL);
        st.p0_star    = (p_reg[0] == CH_STAR);
        st.p0_quest   = (p_reg[0] == CH_QUEST);
        st.p0_lbr     = (p_reg[0] == CH_LBR);
        st.p1_rbr     = (p_reg[1] == CH_RBR);
        st.lit_eq     = (fp0 == fold(nb_reg, cs_reg));
        st.cls_break  = (p_reg[0] == CH_RBR) && (p_reg[1] != CH_RBR);
        st.found      = found_reg;
        st.run_term   = (p_reg[0] == CH_NUL) || (p_reg[0] == CH_STAR)
                        || (p_reg[0] == CH_QUEST);
        st.run_zero   = (run_reg == '0);
        st.run_gt_rem = (run_reg > rem);
        st.cmp_eq     = (fold(nbyte, cs_reg) == fold(pb, cs_reg));
        st.cmp_last_j = ((j_reg + PW'(1)) == run_reg);
        st.cmp_last_i = (i_reg == lim_reg);
    end

    always_comb
    begin
        pl_next      = pl_reg;
        nl_next      = nl_reg;
        f_next       = f_reg;
        n_next       = n_reg;
        s_next       = s_reg;
        run_next     = run_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        lim_next     = lim_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        nb_next      = nb_reg;
        nc_next      = nc_reg;
        found_next   = found_reg;
        matched_next = matched_reg;
        done_next    = 1'b0;
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                unique case (kind_t'(kind))
                    KIND_PAT:
                    begin
                        if (p_we)
                        begin
                            pl_next = pl_reg + AW'(1);
                        end
                    end
                    KIND_NAME:
                    begin
                        if (n_we)
                        begin
                            nl_next = nl_reg + AW'(1);
                        end
                    end
                    KIND_EVAL:
                    begin
                        f_next = '0;
                        n_next = '0;
                        k_next = '0;
                    end
                    KIND_CLR:
                    begin
                        pl_next = '0;
                    end
                    default:
                    begin
                        pl_next = pl_reg;
                    end
                endcase
            end
            OP_WIN:
            begin
                if (k_reg != 3'd0)
                begin
                    p_next[0] = p_reg[1];
                    p_next[1] = p_reg[2];
                    p_next[2] = p_reg[3];
                    p_next[3] = pb;
                end
                if (k_reg == 3'd1)
                begin
                    nb_next = nbyte;
                end
                k_next = (k_reg == 3'd4) ? 3'd0 : k_reg + 3'd1;
            end
            OP_ADV:
            begin
                f_next = f_reg + PW'(1);
                n_next = n_reg + PW'(1);
            end
            OP_F1:
            begin
                f_next = f_reg + PW'(1);
            end
            OP_STAR:
            begin
                f_next   = f_reg + PW'(1);
                s_next   = f_reg + PW'(1);
                run_next = '0;
            end
            OP_RUN:
            begin
                f_next   = f_reg + PW'(1);
                run_next = run_reg + PW'(1);
            end
            OP_CLS_OPEN:
            begin
                nc_next    = fold(nb_reg, cs_reg);
                f_next     = f_reg + PW'(1);
                found_next = 1'b0;
            end
            OP_CLS_STEP:
            begin
                if (is_range)
                begin
                    if (nc_reg >= fp0 && nc_reg <= fp2)
                    begin
                        found_next = 1'b1;
                    end
                    f_next = f_reg + PW'(3);
                end
                else
                begin
                    if (fp0 == nc_reg)
                    begin
                        found_next = 1'b1;
                    end
                    f_next = f_reg + PW'(1);
                end
            end
            OP_CMP_INIT:
            begin
                i_next   = '0;
                j_next   = '0;
                lim_next = rem - run_reg;
            end
            OP_CMP_ISSUE:
            begin
                i_next = i_reg;
            end
            OP_CMP_TEST:
            begin
                if (st.cmp_eq)
                begin
                    if (st.cmp_last_j)
                    begin
                        n_next = n_reg + i_reg + run_reg;
                    end
                    else
                    begin
                        j_next = j_reg + PW'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + PW'(1);
                    j_next = '0;
                end
            end
            OP_FIN_T:
            begin
                matched_next = 1'b1;
                done_next    = 1'b1;
                nl_next      = '0;
            end
            OP_FIN_F:
            begin
                matched_next = 1'b0;
                done_next    = 1'b1;
                nl_next      = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg   <= '0;
            nl_reg   <= '0;
            cs_reg   <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            pl_reg   <= pl_next;
            nl_reg   <= nl_next;
            done_reg <= done_next;
            k_reg    <= k_next;
            if (cfg_we)
            begin
                cs_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg       <= f_next;
        n_reg       <= n_next;
        s_reg       <= s_next;
        run_reg     <= run_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        lim_reg     <= lim_next;
        p_reg       <= p_next;
        nb_reg      <= nb_next;
        nc_reg      <= nc_next;
        found_reg   <= found_next;
        matched_reg <= matched_next;
        p_ok_reg    <= (pa < PW'(pl_reg));
        n_ok_reg    <= (na < PW'(nl_reg));
    end

    assign done    = done_reg;
    assign matched = matched_reg;

endmodule

[rtl/wildcard_path_filter_match_unit.sv]
// Top level of the wildcard path filter match unit.
// Depends on wpf_pkg, wpf_ctrl and wpf_dp.
//
//   channel   ports                         handshake
//   input     kind, char_value              start high while busy low
//   result    matched                       done high for one cycle
//   config    cfg_wdata                     cfg_we high
//
// Pattern and name byte loads and pattern clears never raise busy.
// An evaluate item is accepted, then each pattern step takes a window fetch and a
// decision, and each byte compare of a star search takes an issue and a test state.
// Busy stays high until the verdict, which appears on done and matched in the first
// cycle with busy low; the receiver cannot stall.
// Reset is asynchronous and empties both stores; no clearing pass is needed.
module wildcard_path_filter_match_unit
    import wpf_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] char_value,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    output logic       done,
    output logic       matched
);

    cmd_t    cmd;
    status_t st;

    wpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    wpf_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .char_value (char_value),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .st         (st),
        .done       (done),
        .matched    (matched)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("verdict without evaluation");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("verdict while still busy");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_EVAL) |=> busy)
        else $error("evaluate item did not start");

endmodule

[sim/tb_wildcard_path_filter_match_unit.sv]
// Testbench for the wildcard path filter match unit: glob verdicts checked against
// an in-bench predictor over directed and random item streams. Depends on wpf_pkg and wildcard_path_filter_match_unit.
`timescale 1ns / 100ps

module tb_wildcard_path_filter_match_unit;
    import wpf_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t what;
        kind_t      kind;
        logic [7:0] ch;
        int         idle_pct;
        logic       cfg_val;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] kind = KIND_PAT;
    logic [7:0] char_value = 8'h00;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       done;
    logic       matched;

    step_t      step_q[$];
    logic       verdict_q[$];
    logic [7:0] pat_mem[STORE_DEPTH];
    logic [7:0] name_mem[STORE_DEPTH];
    int         pat_len = 0;
    int         name_len = 0;
    logic       exact_case = 1'b0;
    logic       accepted = 1'b0;
    int         calm = 0;
    int         stuck = 0;
    int         mismatches = 0;
    int         sender_idle = 0;
    int         item_count = 0;

    wildcard_path_filter_match_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .char_value (char_value),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .matched    (matched)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] to_slash(input logic [7:0] c);
        return (c == CH_BSLASH || c == CH_COLON) ? CH_SLASH : c;
    endfunction

    function automatic logic [7:0] upc(input logic [7:0] c);
        if (!exact_case && c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_at(input int i);
        return (i < pat_len && i < STORE_DEPTH) ? pat_mem[i] : CH_NUL;
    endfunction

    function automatic logic [7:0] name_at(input int i);
        return (i < name_len && i < STORE_DEPTH) ? name_mem[i] : CH_NUL;
    endfunction

    function automatic logic glob_verdict();
        int f;
        int n;
        int st;
        int run;
        int rem;
        int i;
        int j;
        logic hit;
        logic found;
        logic [7:0] c;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] nc;
        f = 0;
        n = 0;
        while (pat_at(f) != CH_NUL)
        begin
            c = pat_at(f);
            if (c == CH_STAR)
            begin
                f++;
                st = f;
                run = 0;
                hit = 1'b0;
                while (pat_at(f) != CH_NUL && pat_at(f) != CH_STAR && pat_at(f) != CH_QUEST)
                begin
                    f++;
                    run++;
                end
                if (run != 0)
                begin
                    rem = (n < name_len) ? name_len - n : 0;
                    if (run > rem)
                    begin
                        return 1'b0;
                    end
                    for (i = 0; i <= rem - run && !hit; i++)
                    begin
                        for (j = 0; j < run; j++)
                        begin
                            if (upc(name_at(n + i + j)) != upc(pat_at(st + j)))
                            begin
                                break;
                            end
                        end
                        if (j == run)
                        begin
                            hit = 1'b1;
                            n = n + i + run;
                        end
                    end
                    if (!hit)
                    begin
                        return 1'b0;
                    end
                end
            end
            else if (c == CH_QUEST)
            begin
                f++;
                n++;
            end
            else if (c == CH_LBR && pat_at(f + 1) == CH_RBR)
            begin
                f++;
            end
            else if (c == CH_LBR)
            begin
                found = 1'b0;
                nc = upc(name_at(n));
                f++;
                while (pat_at(f) != CH_NUL && !found)
                begin
                    a = pat_at(f);
                    b = pat_at(f + 2);
                    if (a == CH_RBR && pat_at(f + 1) != CH_RBR)
                    begin
                        break;
                    end
                    if (pat_at(f + 1) == CH_DASH && b != CH_NUL &&
                        (b != CH_RBR || pat_at(f + 3) == CH_RBR))
                    begin
                        if (nc >= upc(a) && nc <= upc(b))
                        begin
                            found = 1'b1;
                        end
                        f += 3;
                    end
                    else
                    begin
                        if (upc(a) == nc)
                        begin
                            found = 1'b1;
                        end
                        f++;
                    end
                end
                if (!found)
                begin
                    return 1'b0;
                end
                while (pat_at(f) != CH_NUL)
                begin
                    if (pat_at(f) == CH_RBR && pat_at(f + 1) != CH_RBR)
                    begin
                        break;
                    end
                    f++;
                end
                f++;
                n++;
            end
            else
            begin
                if (upc(c) != upc(name_at(n)))
                begin
                    return 1'b0;
                end
                f++;
                n++;
            end
        end
        return 1'b1;
    endfunction

    function automatic void apply_item(input logic [1:0] k, input logic [7:0] c);
        case (kind_t'(k))
            KIND_PAT:
            begin
                if (c != CH_NUL && pat_len < STORE_DEPTH - 1)
                begin
                    pat_mem[pat_len] = to_slash(c);
                    pat_len++;
                end
            end
            KIND_NAME:
            begin
                if (c != CH_NUL && name_len < STORE_DEPTH - 1)
                begin
                    name_mem[name_len] = to_slash(c);
                    name_len++;
                end
            end
            KIND_EVAL:
            begin
                verdict_q.push_back(glob_verdict());
                name_len = 0;
            end
            default:
            begin
                pat_len = 0;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        accepted <= start && !busy;
        if (start && !busy)
        begin
            apply_item(kind, char_value);
        end
        if (cfg_we)
        begin
            exact_case = cfg_wdata;
        end
        if (done)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected verdict matched=%0b", matched);
                end
            end
            else
            begin
                if (matched !== verdict_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("verdict mismatch: expected %0b, got %0b",
                                 verdict_q[0], matched);
                    end
                end
                void'(verdict_q.pop_front());
            end
        end
        calm <= (busy || done || (start && !busy)) ? 0 : calm + 1;
        if ((start && !busy) || done || cfg_we)
        begin
            stuck <= 0;
        end
        else
        begin
            stuck <= stuck + 1;
        end
        if (stuck >= WATCHDOG_LIMIT)
        begin
            $display("** wildcard_path_filter_match_unit: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin : drive
        logic nxt_start;
        logic nxt_we;
        logic quiet;
        nxt_start = start;
        nxt_we = 1'b0;
        quiet = (verdict_q.size() == 0) && (calm >= SETTLE_CYCLES) && !busy;
        if (rst_n && (!start || accepted))
        begin
            nxt_start = 1'b0;
            if (step_q.size() > 0)
            begin
                case (step_q[0].what)
                    STEP_ITEM:
                    begin
                        if ($urandom_range(99) >= step_q[0].idle_pct)
                        begin
                            kind <= step_q[0].kind;
                            char_value <= step_q[0].ch;
                            nxt_start = 1'b1;
                            void'(step_q.pop_front());
                        end
                    end
                    STEP_CFG:
                    begin
                        if (quiet && !start)
                        begin
                            cfg_wdata <= step_q[0].cfg_val;
                            nxt_we = 1'b1;
                            void'(step_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet && !start)
                        begin
                            void'(step_q.pop_front());
                        end
                    end
                endcase
            end
        end
        start <= nxt_start;
        cfg_we <= nxt_we;
    end

    task automatic push_item(input kind_t k, input logic [7:0] c);
        step_t s;
        s.what = STEP_ITEM;
        s.kind = k;
        s.ch = c;
        s.idle_pct = sender_idle;
        s.cfg_val = 1'b0;
        step_q.push_back(s);
        item_count++;
    endtask

    task automatic push_ctl(input step_kind_t w, input logic v);
        step_t s;
        s.what = w;
        s.kind = KIND_PAT;
        s.ch = CH_NUL;
        s.idle_pct = 0;
        s.cfg_val = v;
        step_q.push_back(s);
    endtask

    task automatic push_text(input kind_t k, input string txt);
        for (int i = 0; i < txt.len(); i++)
        begin
            push_item(k, txt[i]);
        end
    endtask

    task automatic push_case(input string pat, input string nm);
        push_item(KIND_CLR, CH_NUL);
        push_text(KIND_PAT, pat);
        push_text(KIND_NAME, nm);
        push_item(KIND_EVAL, CH_NUL);
    endtask

    function automatic logic [7:0] rand_sym();
        string alpha;
        alpha = "abcAB/\\:*?[]-xz.";
        if ($urandom_range(9) == 0)
        begin
            return 8'($urandom_range(255));
        end
        return alpha[$urandom_range(alpha.len() - 1)];
    endfunction

    task automatic push_random_case();
        logic [7:0] pat[$];
        int plen;
        int k;
        plen = ($urandom_range(19) == 0) ? 70 : $urandom_range(10);
        if ($urandom_range(9) == 0)
        begin
            push_item(kind_t'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        for (int i = 0; i < plen; i++)
        begin
            pat.push_back(rand_sym());
        end
        if ($urandom_range(3) != 0)
        begin
            push_item(KIND_CLR, CH_NUL);
            foreach (pat[i])
            begin
                push_item(KIND_PAT, pat[i]);
            end
        end
        if ($urandom_range(1) == 0)
        begin
            k = 0;
            while (k < pat.size())
            begin
                if (pat[k] == CH_STAR)
                begin
                    repeat ($urandom_range(3)) push_item(KIND_NAME, rand_sym());
                end
                else if (pat[k] == CH_QUEST)
                begin
                    push_item(KIND_NAME, rand_sym());
                end
                else if (pat[k] == CH_LBR && k + 1 < pat.size())
                begin
                    k++;
                    push_item(KIND_NAME, pat[k]);
                    while (k < pat.size() && pat[k] != CH_RBR)
                    begin
                        k++;
                    end
                end
                else
                begin
                    push_item(KIND_NAME, pat[k]);
                end
                k++;
            end
        end
        else
        begin
            repeat ($urandom_range(12)) push_item(KIND_NAME, rand_sym());
        end
        push_item(KIND_EVAL, CH_NUL);
    endtask

    initial
    begin
        push_ctl(STEP_CFG, 1'b0);
        push_case("*.TXT", "dir\\a:b.txt");
        push_case("a?[b-d][]]x", "aZc]x");
        push_case("[]x", "x");
        push_case("[a-]", "-");
        push_case("ab", "abcdef");
        push_case("a?[xy", "a");
        push_item(KIND_PAT, CH_NUL);
        push_item(KIND_NAME, CH_NUL);
        push_item(KIND_EVAL, CH_NUL);
        push_case("*", "");
        push_case("*q", "zz");
        push_case("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa",
                  "aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
        push_case("?*", "");
        push_case("[^-~]", "\xFF");
        push_ctl(STEP_DRAIN, 1'b0);
        push_ctl(STEP_CFG, 1'b1);
        push_case("*.TXT", "dir/a.txt");
        push_case("[A-Z]b", "Ab");
        sender_idle = 18;
        while (item_count < 400)
        begin
            push_random_case();
        end
        push_ctl(STEP_DRAIN, 1'b0);
        push_ctl(STEP_CFG, 1'b0);
        sender_idle = 66;
        while (item_count < 750)
        begin
            push_random_case();
        end
        push_ctl(STEP_DRAIN, 1'b0);
        push_ctl(STEP_CFG, 1'b1);
        sender_idle = 0;
        while (item_count < 950)
        begin
            push_random_case();
        end
        push_ctl(STEP_DRAIN, 1'b0);
        push_ctl(STEP_CFG, 1'b0);
        while (item_count < 1050)
        begin
            push_random_case();
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (step_q.size() != 0 || start || verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("** wildcard_path_filter_match_unit: PASSED **");
        end
        else
        begin
            $display("** wildcard_path_filter_match_unit: FAILED **");
        end
        $finish;
    end

endmodule
